// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the matrix multiplier RTL. Defining
// NO_ASSERTIONS turns every use into an empty statement.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked at each rising edge, ignored while reset is high.
`define FMM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fmm assertion failed");
// Property checked at every rising edge, reset included.
`define FMM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("fmm assertion failed");
`else
`define FMM_ASSERT(label, clk, rst, prop)
`define FMM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: sv/fmm_pkg.sv
// ----------------------------------------------------------------------------
// fmm_pkg
// Shared types and constants of the single-precision matrix multiplier.
// ----------------------------------------------------------------------------
package fmm_pkg;

   // Largest supported matrix dimension.
   localparam int MAX_DIM_DEFAULT = 8;

   // Field widths.
   localparam int DATA_W    = 32;
   localparam int IDX_W     = 3;
   localparam int DIM_W     = 4;
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 2;

   // Reset value of every dimension register.
   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   // Operation codes of a request transaction.
   localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
   localparam logic [OP_W-1:0] OP_START  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   // Request payload.
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] value;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [IDX_W-1:0]  out_row;
      logic [IDX_W-1:0]  out_col;
      logic [DATA_W-1:0] result;
      logic              last;
   } rsp_type;

   // Stage strobes from the sequencer to the arithmetic unit.
   typedef struct packed {
      logic clr;
      logic mul;
      logic pnl;
      logic pns;
      logic aln;
      logic add;
      logic lzc;
      logic rnd;
      logic fin;
   } fpu_ctl_type;

endpackage

// File: sv/fmm_stream_if.sv
// ----------------------------------------------------------------------------
// fmm_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface fmm_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/fmm_ram.sv
// ----------------------------------------------------------------------------
// fmm_ram
// Matrix element store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fmm_ram #(
   parameter int DEPTH  = fmm_pkg::MAX_DIM_DEFAULT * fmm_pkg::MAX_DIM_DEFAULT,
   parameter int ADDR_W = 6
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [fmm_pkg::DATA_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [fmm_pkg::DATA_W-1:0]  rd_data
);
   import fmm_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write when wr_en is high and read every cycle; read data is registered and appears in the next cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/fmm_fpu.sv
// ----------------------------------------------------------------------------
// fmm_fpu
// Multiply-accumulate unit: exact single-precision product, double-precision
// accumulation with round to nearest even, final rounding to single.
// ----------------------------------------------------------------------------
module fmm_fpu (
   input  logic                        clock,
   input  fmm_pkg::fpu_ctl_type        ctl,
   input  logic [fmm_pkg::DATA_W-1:0]  a_bits,
   input  logic [fmm_pkg::DATA_W-1:0]  b_bits,
   output logic [fmm_pkg::DATA_W-1:0]  result_bits
);
   import fmm_pkg::*;

   localparam int EXP_W  = 12;
   localparam int PROD_W = 48;
   localparam int MAN_W  = 53;
   localparam int EXT_W  = MAN_W + 3;
   localparam int SUM_W  = EXT_W + 1;
   localparam int FSH_W  = 55;
   localparam int FW_W   = MAN_W + 2 + 64;
   localparam logic [DATA_W-1:0]       CANON_NAN = 32'h7FC0_0000;
   localparam logic signed [EXP_W-1:0] SHIFT_CAP = 12'sd63;
   localparam logic signed [EXP_W-1:0] EXP_ONE   = 12'sd1;
   localparam logic signed [EXP_W-1:0] BIAS_F    = 12'sd127;
   localparam logic signed [EXP_W-1:0] EXP_MAX_F = 12'sd255;
   localparam logic signed [EXP_W-1:0] PROD_ADJ  = 12'sd253;

   // Leading zero count of a 64-bit word; 64 when the word is zero.
   function automatic logic [6:0] lzc64(input logic [63:0] v);
      logic [6:0] n;
      logic       found;
      n     = 7'd64;
      found = 1'b0;
      for (int b = 63; b >= 0; b--) begin
         if (!found && v[b]) begin
            n     = 7'(63 - b);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // Operand decode.
   logic [7:0]  ea, eb;
   logic [22:0] fa, fb;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, p_nan;
   logic [23:0] ma, mb;
   logic signed [EXP_W-1:0] ea_n, eb_n;

   assign ea     = a_bits[30:23];
   assign eb     = b_bits[30:23];
   assign fa     = a_bits[22:0];
   assign fb     = b_bits[22:0];
   assign a_nan  = (ea == 8'hFF) && (fa != 23'd0);
   assign b_nan  = (eb == 8'hFF) && (fb != 23'd0);
   assign a_inf  = (ea == 8'hFF) && (fa == 23'd0);
   assign b_inf  = (eb == 8'hFF) && (fb == 23'd0);
   assign a_zero = (ea == 8'd0) && (fa == 23'd0);
   assign b_zero = (eb == 8'd0) && (fb == 23'd0);
   assign p_nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
   assign ma     = {ea != 8'd0, fa};
   assign mb     = {eb != 8'd0, fb};
   assign ea_n   = (ea == 8'd0) ? EXP_ONE : EXP_W'(ea);
   assign eb_n   = (eb == 8'd0) ? EXP_ONE : EXP_W'(eb);

   // Product registers.
   logic [PROD_W-1:0]       prod_ff;
   logic signed [EXP_W-1:0] pexp_ff;
   logic                    psign_ff, pnan_ff, pinf_ff;

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         prod_ff  <= ma * mb;
         pexp_ff  <= ea_n + eb_n - PROD_ADJ;
         psign_ff <= a_bits[31] ^ b_bits[31];
         pnan_ff  <= p_nan;
         pinf_ff  <= (a_inf || b_inf) && !p_nan;
      end
   end

   // Product normalization: count, then shift.
   logic [6:0]              plz_ff;
   logic                    pzero_ff;
   logic [PROD_W-1:0]       pnorm;
   logic [MAN_W-1:0]        ym_ff;
   logic signed [EXP_W-1:0] ye_ff;

   assign pnorm = prod_ff << plz_ff[5:0];

   always_ff @(posedge clock) begin
      if (ctl.pnl) begin
         plz_ff   <= lzc64({prod_ff, 16'd0});
         pzero_ff <= (prod_ff == '0);
      end
      if (ctl.pns) begin
         ym_ff <= {pnorm, 5'd0};
         ye_ff <= pexp_ff - $signed({5'd0, plz_ff});
      end
   end

   // Accumulator.
   logic                    acc_zero_ff, acc_sign_ff;
   logic signed [EXP_W-1:0] acc_exp_ff;
   logic [MAN_W-1:0]        acc_man_ff;
   logic                    acc_nan_ff, acc_inf_ff, acc_inf_sign_ff;

   // Alignment: order the operands by magnitude and shift the smaller one.
   logic                    x_ge, big_sign, sm_sign, sm_zero;
   logic [MAN_W-1:0]        big_man, sm_man;
   logic signed [EXP_W-1:0] big_exp, sm_exp, exp_diff;
   logic [5:0]              dcap;
   logic [2*EXT_W-1:0]      wide;
   logic [EXT_W-1:0]        small_ext;

   assign x_ge = (acc_exp_ff > ye_ff) || ((acc_exp_ff == ye_ff) && (acc_man_ff >= ym_ff));

   always_comb begin
      if (acc_zero_ff || (!pzero_ff && !x_ge)) begin
         big_man  = ym_ff;
         big_exp  = ye_ff;
         big_sign = psign_ff;
         sm_man   = acc_man_ff;
         sm_exp   = acc_exp_ff;
         sm_sign  = acc_sign_ff;
         sm_zero  = acc_zero_ff;
      end else begin
         big_man  = acc_man_ff;
         big_exp  = acc_exp_ff;
         big_sign = acc_sign_ff;
         sm_man   = ym_ff;
         sm_exp   = ye_ff;
         sm_sign  = psign_ff;
         sm_zero  = pzero_ff;
      end
   end

   assign exp_diff  = big_exp - sm_exp;
   assign dcap      = (exp_diff > SHIFT_CAP) ? 6'd63 : exp_diff[5:0];
   assign wide      = {sm_man, 3'd0, {EXT_W{1'b0}}} >> dcap;
   assign small_ext = sm_zero ? '0
                    : (wide[2*EXT_W-1:EXT_W] | {{(EXT_W-1){1'b0}}, |wide[EXT_W-1:0]});

   logic [EXT_W-1:0]        aln_big_ff, aln_small_ff;
   logic                    aln_sign_ff, aln_sub_ff, aln_zero_ff;
   logic signed [EXP_W-1:0] aln_exp_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic [6:0]              slz_ff;

   always_ff @(posedge clock) begin
      if (ctl.aln) begin
         aln_big_ff   <= {big_man, 3'd0};
         aln_small_ff <= small_ext;
         aln_sign_ff  <= big_sign;
         aln_sub_ff   <= (big_sign != sm_sign) && !sm_zero;
         aln_exp_ff   <= big_exp;
         aln_zero_ff  <= acc_zero_ff && pzero_ff;
      end
      if (ctl.add) begin
         sum_ff <= aln_sub_ff ? ({1'b0, aln_big_ff} - {1'b0, aln_small_ff})
                              : ({1'b0, aln_big_ff} + {1'b0, aln_small_ff});
      end
      if (ctl.lzc) begin
         slz_ff <= lzc64({sum_ff, 7'd0});
      end
   end

   // Normalize and round the sum to double precision.
   logic [SUM_W-1:0]        snorm;
   logic                    s_guard, s_sticky, s_up, res_zero;
   logic [MAN_W:0]          man_r;
   logic signed [EXP_W-1:0] exp_n;

   assign snorm    = sum_ff << slz_ff[5:0];
   assign s_guard  = snorm[3];
   assign s_sticky = |snorm[2:0];
   assign s_up     = s_guard && (s_sticky || snorm[4]);
   assign man_r    = {1'b0, snorm[SUM_W-1:4]} + (MAN_W+1)'(s_up);
   assign exp_n    = aln_exp_ff + EXP_ONE - $signed({5'd0, slz_ff});
   assign res_zero = aln_zero_ff || (sum_ff == '0);

   always_ff @(posedge clock) begin
      if (ctl.clr) begin
         acc_zero_ff     <= 1'b1;
         acc_sign_ff     <= 1'b0;
         acc_nan_ff      <= 1'b0;
         acc_inf_ff      <= 1'b0;
         acc_inf_sign_ff <= 1'b0;
      end else if (ctl.rnd) begin
         acc_zero_ff <= res_zero;
         acc_sign_ff <= res_zero ? 1'b0 : aln_sign_ff;
         if (man_r[MAN_W]) begin
            acc_man_ff <= {1'b1, {(MAN_W-1){1'b0}}};
            acc_exp_ff <= exp_n + EXP_ONE;
         end else begin
            acc_man_ff <= man_r[MAN_W-1:0];
            acc_exp_ff <= exp_n;
         end
         acc_nan_ff      <= acc_nan_ff || pnan_ff
                            || (pinf_ff && acc_inf_ff && (psign_ff != acc_inf_sign_ff));
         acc_inf_ff      <= acc_inf_ff || pinf_ff;
         acc_inf_sign_ff <= acc_inf_ff ? acc_inf_sign_ff : psign_ff;
      end
   end

   // Conversion to single: denormalizing shift first.
   logic signed [EXP_W-1:0] f_ef, f_sham;
   logic                    f_sub;
   logic [5:0]              f_cap;
   logic [FW_W-1:0]         fwide;
   logic [FSH_W-1:0]        fsh_ff;
   logic signed [EXP_W-1:0] fef_ff;
   logic                    fsub_ff;

   assign f_ef   = acc_exp_ff + BIAS_F;
   assign f_sub  = f_ef < EXP_ONE;
   assign f_sham = EXP_ONE - f_ef;
   assign f_cap  = !f_sub ? 6'd0 : ((f_sham > SHIFT_CAP) ? 6'd63 : f_sham[5:0]);
   assign fwide  = {acc_man_ff, 2'd0, 64'd0} >> f_cap;

   always_ff @(posedge clock) begin
      if (ctl.fin) begin
         fsh_ff  <= fwide[FW_W-1 -: FSH_W] | {{(FSH_W-1){1'b0}}, |fwide[63:0]};
         fef_ff  <= f_ef;
         fsub_ff <= f_sub;
      end
   end

   // Final rounding and packing.
   logic                    f_up;
   logic [24:0]             fmr;
   logic signed [EXP_W-1:0] f_expf;
   logic                    f_ovf;

   assign f_up   = fsh_ff[30] && ((|fsh_ff[29:0]) || fsh_ff[31]);
   assign fmr    = {1'b0, fsh_ff[54:31]} + 25'(f_up);
   assign f_expf = fef_ff + EXP_W'(fmr[24]);
   assign f_ovf  = f_expf >= EXP_MAX_F;

   always_comb begin
      priority if (acc_nan_ff) begin
         result_bits = CANON_NAN;
      end else if (acc_inf_ff) begin
         result_bits = {acc_inf_sign_ff, 8'hFF, 23'd0};
      end else if (acc_zero_ff) begin
         result_bits = '0;
      end else if (fsub_ff) begin
         result_bits = {acc_sign_ff, 7'd0, fmr[23], fmr[22:0]};
      end else if (f_ovf) begin
         result_bits = {acc_sign_ff, 8'hFF, 23'd0};
      end else begin
         result_bits = {acc_sign_ff, f_expf[7:0], fmr[22:0]};
      end
   end

endmodule

// File: sv/float_matrix_multiply.sv
// ----------------------------------------------------------------------------
// float_matrix_multiply
// Single-precision matrix multiplier C = A x B with element stores in RAM.
// ----------------------------------------------------------------------------
//  Channel    Direction  Transaction
//  req_chan   in         load A element, load B element, or start multiply
//  rsp_chan   out        one element of C, row-major, last on final element
//  csr_*      in         write of rows_a, inner_dim or cols_b
//
// A load leaves the sequencer idle; the next request is taken in the following cycle.
// A start runs, for each element of C, one pass per inner term through read,
// multiply, two product normalization steps, align, add, count and round in
// one shared unit, then final rounding in FIN1 and FIN2, which waits out any
// response stall. Requests are held off until the last element is queued.
// Reset is synchronous; the element stores are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module float_matrix_multiply #(
   parameter int MAX_DIM = fmm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   fmm_stream_if.sink                     req_chan,
   fmm_stream_if.source                   rsp_chan,
   input  logic                           csr_we,
   input  logic [fmm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fmm_pkg::DIM_W-1:0]      csr_wdata
);
   import fmm_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,
      ST_RD   = 11'b000_0000_0010,
      ST_MUL  = 11'b000_0000_0100,
      ST_PNL  = 11'b000_0000_1000,
      ST_PNS  = 11'b000_0001_0000,
      ST_ALN  = 11'b000_0010_0000,
      ST_ADD  = 11'b000_0100_0000,
      ST_LZC  = 11'b000_1000_0000,
      ST_RND  = 11'b001_0000_0000,
      ST_FIN1 = 11'b010_0000_0000,
      ST_FIN2 = 11'b100_0000_0000
   } state_type;

   // Last valid index for a dimension register value.
   function automatic logic [IDX_W-1:0] clamp_last(input logic [DIM_W-1:0] d);
      logic [IDX_W-1:0] r;
      if (d == '0) begin
         r = '0;
      end else if (int'(d) > MAX_DIM) begin
         r = IDX_W'(MAX_DIM - 1);
      end else begin
         r = IDX_W'(d - DIM_W'(1));
      end
      return r;
   endfunction

   state_type        state_ff, state_in;
   logic [DIM_W-1:0] rows_ff, inner_ff, cols_ff;
   logic [IDX_W-1:0] nr_ff, nk_ff, nc_ff, nr_in, nk_in, nc_in;
   logic [IDX_W-1:0] i_ff, j_ff, k_ff, i_in, j_in, k_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;

   logic        req_acc, start_acc, in_range, a_we, b_we;
   logic        rsp_load, elem_last;
   logic [ADDR_W-1:0] wr_addr, a_raddr, b_raddr;
   logic [DATA_W-1:0] a_rdata, b_rdata, fpu_result;
   fpu_ctl_type       fpu_ctl;

   // Request side: loads write the stores, start launches the sequencer.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc   = req_chan.valid && req_chan.ready;
   assign start_acc = req_acc && (req_chan.data.op == OP_START);
   assign in_range  = (int'(req_chan.data.row) < MAX_DIM) && (int'(req_chan.data.col) < MAX_DIM);
   assign a_we      = req_acc && in_range && (req_chan.data.op == OP_LOAD_A);
   assign b_we      = req_acc && in_range && (req_chan.data.op == OP_LOAD_B);
   assign wr_addr   = ADDR_W'(int'(req_chan.data.row) * MAX_DIM + int'(req_chan.data.col));
   assign a_raddr   = ADDR_W'(int'(i_ff) * MAX_DIM + int'(k_ff));
   assign b_raddr   = ADDR_W'(int'(k_ff) * MAX_DIM + int'(j_ff));

   fmm_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (wr_addr),
      .wr_data (req_chan.data.value),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   fmm_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (wr_addr),
      .wr_data (req_chan.data.value),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   // Response side: output register frees when the consumer takes it.
   assign elem_last = (i_ff == nr_ff) && (j_ff == nc_ff);
   assign rsp_load  = (state_ff == ST_FIN2) && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Stage strobes for the arithmetic unit.
   assign fpu_ctl.clr = (state_ff == ST_IDLE) || rsp_load;
   assign fpu_ctl.mul = (state_ff == ST_MUL);
   assign fpu_ctl.pnl = (state_ff == ST_PNL);
   assign fpu_ctl.pns = (state_ff == ST_PNS);
   assign fpu_ctl.aln = (state_ff == ST_ALN);
   assign fpu_ctl.add = (state_ff == ST_ADD);
   assign fpu_ctl.lzc = (state_ff == ST_LZC);
   assign fpu_ctl.rnd = (state_ff == ST_RND);
   assign fpu_ctl.fin = (state_ff == ST_FIN1);

   fmm_fpu u_fpu (
      .clock       (clock),
      .ctl         (fpu_ctl),
      .a_bits      (a_rdata),
      .b_bits      (b_rdata),
      .result_bits (fpu_result)
   );

   // Sequencer over rows, columns and inner terms.
   always_comb begin
      state_in = state_ff;
      nr_in    = nr_ff;
      nk_in    = nk_ff;
      nc_in    = nc_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_acc) begin
               nr_in    = clamp_last(rows_ff);
               nk_in    = clamp_last(inner_ff);
               nc_in    = clamp_last(cols_ff);
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = ST_RD;
            end
         end
         ST_RD:  state_in = ST_MUL;
         ST_MUL: state_in = ST_PNL;
         ST_PNL: state_in = ST_PNS;
         ST_PNS: state_in = ST_ALN;
         ST_ALN: state_in = ST_ADD;
         ST_ADD: state_in = ST_LZC;
         ST_LZC: state_in = ST_RND;
         ST_RND: begin
            if (k_ff == nk_ff) begin
               state_in = ST_FIN1;
            end else begin
               k_in     = k_ff + IDX_W'(1);
               state_in = ST_RD;
            end
         end
         ST_FIN1: state_in = ST_FIN2;
         ST_FIN2: begin
            if (rsp_load) begin
               k_in = '0;
               if (elem_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RD;
                  if (j_ff == nc_ff) begin
                     j_in = '0;
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= DIM_RESET;
         inner_ff     <= DIM_RESET;
         cols_ff      <= DIM_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ROWS_A:    rows_ff  <= csr_wdata;
               CSR_INNER_DIM: inner_ff <= csr_wdata;
               CSR_COLS_B:    cols_ff  <= csr_wdata;
               default:       ;
            endcase
         end
      end
   end

   // Counters and response payload.
   always_ff @(posedge clock) begin
      nr_ff <= nr_in;
      nk_ff <= nk_in;
      nc_ff <= nc_in;
      i_ff  <= i_in;
      j_ff  <= j_in;
      k_ff  <= k_in;
      if (rsp_load) begin
         rsp_data_ff.out_row <= i_ff;
         rsp_data_ff.out_col <= j_ff;
         rsp_data_ff.result  <= fpu_result;
         rsp_data_ff.last    <= elem_last;
      end
   end

   // A start transaction always begins a read of the first term.
   `FMM_ASSERT(a_start_reads, clock, reset, start_acc |=> (state_ff == ST_RD))
   // A blocked response freezes the element position.
   `FMM_ASSERT(a_stall_holds, clock, reset, (state_ff == ST_FIN2 && rsp_valid_ff && !rsp_chan.ready) |=> (state_ff == ST_FIN2 && $stable(i_ff) && $stable(j_ff)))
   // Counters never run past the latched dimensions.
   `FMM_ASSERT(a_idx_bounds, clock, reset, (state_ff != ST_IDLE) |-> (i_ff <= nr_ff && j_ff <= nc_ff && k_ff <= nk_ff))
   // Queuing the final element returns the sequencer to idle.
   `FMM_ASSERT(a_last_idle, clock, reset, (rsp_load && elem_last) |=> (state_ff == ST_IDLE))

endmodule
